// ===== rtl/spl_pkg.sv =====
`timescale 1ns / 1ps

package spl_pkg;

  // Fixed field widths of the channels.
  localparam int KEY_PORT_W = 16;
  localparam int RATING_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  // Command codes of the input item.
  typedef enum logic {
    CMD_RATE   = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // Status codes of the result item.
  typedef enum logic [STATUS_W-1:0] {
    STS_UPDATED   = 2'd0,
    STS_REMOVED   = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  // Step strobes broadcast from the controller to every cell.
  typedef struct packed {
    logic remove_step;
    logic insert_step;
  } cell_ctl_t;

endpackage

// ===== rtl/spl_in_if.sv =====
`timescale 1ns / 1ps

// Command channel: one item per valid/ready handshake.
interface spl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic [spl_pkg::KEY_PORT_W-1:0]        item_key;
  logic signed [spl_pkg::RATING_W-1:0]   item_rating;

  modport source (output valid, output cmd, output item_key, output item_rating,
                  input ready);
  modport sink   (input valid, input cmd, input item_key, input item_rating,
                  output ready);
endinterface

// ===== rtl/spl_out_if.sv =====
`timescale 1ns / 1ps

// Result channel: one item per valid/ready handshake.
interface spl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [spl_pkg::STATUS_W-1:0]          status;
  logic                                  top_valid;
  logic [spl_pkg::KEY_PORT_W-1:0]        top_key;
  logic signed [spl_pkg::RATING_W-1:0]   top_rating;
  logic [spl_pkg::COUNT_W-1:0]           entry_count;

  modport source (output valid, output status, output top_valid, output top_key,
                  output top_rating, output entry_count, input ready);
  modport sink   (input valid, input status, input top_valid, input top_key,
                  input top_rating, input entry_count, output ready);
endinterface

// ===== rtl/sorted_priority_list_upsert_top.sv =====
`timescale 1ns / 1ps
// A command accepted in the idle state has its result written into the output
// register from the insert state, once that register is free.
// The removal step at accept is followed by the insert step in the cell chain;
// none is taken in between. A new command is taken while a result waits.
// Reset (rst_n, synchronous, active low) empties the store and the output
// register; entry contents stay undefined until written.
module sorted_priority_list_upsert_top #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 16
) (
  input logic     clk,
  input logic     rst_n,
  spl_in_if.sink  in_if,
  spl_out_if.source out_if
);

  localparam int CW         = $clog2(DEPTH + 1);
  localparam int PFX_STAGES = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_INSERT = 2'b10
  } state_t;

  state_t                              state_r, state_nxt;
  logic [CW-1:0]                       occ_r, occ_nxt;
  logic [KEY_WIDTH-1:0]                op_key_r;
  logic signed [spl_pkg::RATING_W-1:0] op_rating_r;
  spl_pkg::status_t                    op_status_r;
  logic                                ins_pend_r;
  logic                                out_valid_r;
  spl_pkg::status_t                    out_status_r;
  logic                                out_top_valid_r;
  logic [spl_pkg::KEY_PORT_W-1:0]      out_top_key_r;
  logic signed [spl_pkg::RATING_W-1:0] out_top_rating_r;
  logic [spl_pkg::COUNT_W-1:0]         out_count_r;

  logic                                accept;
  logic                                finish;
  logic                                is_rate;
  logic                                found;
  logic                                full;
  logic                                refuse;
  spl_pkg::status_t                    status_nxt;
  logic [KEY_WIDTH-1:0]                in_key;
  spl_pkg::cell_ctl_t                  ctl;

  logic [DEPTH-1:0]                    cell_valid;
  logic [DEPTH-1:0]                    cell_match;
  logic [DEPTH-1:0]                    cell_ge;
  logic [KEY_WIDTH-1:0]                cell_key [DEPTH];
  logic signed [spl_pkg::RATING_W-1:0] cell_rating [DEPTH];
  logic [DEPTH-1:0]                    pfx [PFX_STAGES+1];

  logic                                res_top_valid;
  logic [KEY_WIDTH-1:0]                res_top_key;
  logic signed [spl_pkg::RATING_W-1:0] res_top_rating;

  // Handshakes.
  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign finish      = (state_r == ST_INSERT) && (!out_valid_r || out_if.ready);

  // Decode of the arriving command; the key is compared on its low bits.
  assign in_key  = KEY_WIDTH'(in_if.item_key);
  assign is_rate = (in_if.cmd == spl_pkg::CMD_RATE);
  assign found   = |cell_match;
  assign full    = (occ_r == CW'(DEPTH));
  assign refuse  = is_rate && !found && full;

  always_comb begin
    if (is_rate) begin
      status_nxt = refuse ? spl_pkg::STS_FULL : spl_pkg::STS_UPDATED;
    end else begin
      status_nxt = found ? spl_pkg::STS_REMOVED : spl_pkg::STS_NOT_FOUND;
    end
  end

  // Prefix OR of the match flags: a slot at or below a match shifts up.
  always_comb begin
    pfx[0] = cell_match;
    for (int s = 0; s < PFX_STAGES; s++) begin
      pfx[s+1] = pfx[s] | (pfx[s] << (1 << s));
    end
  end

  assign ctl.remove_step = accept && found;
  assign ctl.insert_step = finish && ins_pend_r;

  // The chain of slots; slot 0 holds the top entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                                up_valid;
    logic [KEY_WIDTH-1:0]                up_key;
    logic signed [spl_pkg::RATING_W-1:0] up_rating;
    logic                                prev_ge;
    logic                                dn_valid;
    logic [KEY_WIDTH-1:0]                dn_key;
    logic signed [spl_pkg::RATING_W-1:0] dn_rating;

    if (i == DEPTH - 1) begin : g_last
      assign up_valid  = 1'b0;
      assign up_key    = '0;
      assign up_rating = '0;
    end else begin : g_mid
      assign up_valid  = cell_valid[i+1];
      assign up_key    = cell_key[i+1];
      assign up_rating = cell_rating[i+1];
    end

    if (i == 0) begin : g_first
      assign prev_ge   = 1'b1;
      assign dn_valid  = 1'b0;
      assign dn_key    = '0;
      assign dn_rating = '0;
    end else begin : g_rest
      assign prev_ge   = cell_ge[i-1];
      assign dn_valid  = cell_valid[i-1];
      assign dn_key    = cell_key[i-1];
      assign dn_rating = cell_rating[i-1];
    end

    spl_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .probe_key (in_key),
      .new_key   (op_key_r),
      .new_rating(op_rating_r),
      .seen      (pfx[PFX_STAGES][i]),
      .up_valid  (up_valid),
      .up_key    (up_key),
      .up_rating (up_rating),
      .prev_ge   (prev_ge),
      .dn_valid  (dn_valid),
      .dn_key    (dn_key),
      .dn_rating (dn_rating),
      .valid     (cell_valid[i]),
      .key       (cell_key[i]),
      .rating    (cell_rating[i]),
      .match     (cell_match[i]),
      .ge        (cell_ge[i])
    );
  end

  // Top entry as it stands after the insert step of this cycle.
  always_comb begin
    if (ins_pend_r && !cell_ge[0]) begin
      res_top_valid  = 1'b1;
      res_top_key    = op_key_r;
      res_top_rating = op_rating_r;
    end else if (cell_valid[0]) begin
      res_top_valid  = 1'b1;
      res_top_key    = cell_key[0];
      res_top_rating = cell_rating[0];
    end else begin
      res_top_valid  = 1'b0;
      res_top_key    = '0;
      res_top_rating = '0;
    end
  end

  // Sequencer and entry count.
  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_INSERT;
          occ_nxt   = occ_r - CW'(found);
        end
      end
      ST_INSERT: begin
        if (finish) begin
          state_nxt = ST_IDLE;
          occ_nxt   = occ_r + CW'(ins_pend_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Command held for the insert step.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_key_r    <= in_key;
      op_rating_r <= in_if.item_rating;
      op_status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_pend_r <= 1'b0;
    end else if (accept) begin
      ins_pend_r <= is_rate && !refuse;
    end else if (finish) begin
      ins_pend_r <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r     <= op_status_r;
      out_top_valid_r  <= res_top_valid;
      out_top_key_r    <= spl_pkg::KEY_PORT_W'(res_top_key);
      out_top_rating_r <= res_top_rating;
      out_count_r      <= spl_pkg::COUNT_W'(occ_nxt);
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.top_valid   = out_top_valid_r;
  assign out_if.top_key     = out_top_key_r;
  assign out_if.top_rating  = out_top_rating_r;
  assign out_if.entry_count = out_count_r;

endmodule

// ===== rtl/spl_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sorted chain. It takes its lower neighbor's entry on a
// removal step and makes room on an insert step by taking its upper neighbor's
// entry or the new entry.
module spl_cell #(
  parameter int KEY_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spl_pkg::cell_ctl_t                  ctl,
  input  logic [KEY_WIDTH-1:0]                probe_key,
  input  logic [KEY_WIDTH-1:0]                new_key,
  input  logic signed [spl_pkg::RATING_W-1:0] new_rating,
  input  logic                                seen,
  input  logic                                up_valid,
  input  logic [KEY_WIDTH-1:0]                up_key,
  input  logic signed [spl_pkg::RATING_W-1:0] up_rating,
  input  logic                                prev_ge,
  input  logic                                dn_valid,
  input  logic [KEY_WIDTH-1:0]                dn_key,
  input  logic signed [spl_pkg::RATING_W-1:0] dn_rating,
  output logic                                valid,
  output logic [KEY_WIDTH-1:0]                key,
  output logic signed [spl_pkg::RATING_W-1:0] rating,
  output logic                                match,
  output logic                                ge
);

  logic                                valid_r;
  logic [KEY_WIDTH-1:0]                key_r;
  logic signed [spl_pkg::RATING_W-1:0] rating_r;
  logic                                take_up;
  logic                                take_new;
  logic                                take_dn;

  // Local compares against the broadcast key and rating.
  assign match = valid_r && (key_r == probe_key);
  assign ge    = valid_r && (rating_r >= new_rating);

  // A removal at or above this slot pulls the lower entry up. On insert, the first
  // slot that is empty or whose rating falls below the new one takes it, later ones shift.
  assign take_up  = ctl.remove_step && seen;
  assign take_new = ctl.insert_step && !ge && prev_ge;
  assign take_dn  = ctl.insert_step && !ge && !prev_ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_up) begin
      valid_r <= up_valid;
    end else if (take_new) begin
      valid_r <= 1'b1;
    end else if (take_dn) begin
      valid_r <= dn_valid;
    end
  end

  // Entry contents carry no reset.
  always_ff @(posedge clk) begin
    if (take_up) begin
      key_r    <= up_key;
      rating_r <= up_rating;
    end else if (take_new) begin
      key_r    <= new_key;
      rating_r <= new_rating;
    end else if (take_dn) begin
      key_r    <= dn_key;
      rating_r <= dn_rating;
    end
  end

  assign valid  = valid_r;
  assign key    = key_r;
  assign rating = rating_r;

endmodule

// ===== rtl/spl_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks of the sorted list.
module spl_checker #(
  parameter int DEPTH = 16
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [spl_pkg::STATUS_W-1:0]        status,
  input logic                                top_valid,
  input logic [spl_pkg::KEY_PORT_W-1:0]      top_key,
  input logic signed [spl_pkg::RATING_W-1:0] top_rating,
  input logic [spl_pkg::COUNT_W-1:0]         entry_count
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(top_key)
      && $stable(top_rating) && $stable(entry_count) && $stable(top_valid))
    else $error("result changed while stalled");

  // Commands are never accepted on consecutive cycles.
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted on consecutive cycles");

  // The top entry is present exactly when the store is not empty.
  a_top_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH > 31) || (top_valid == (entry_count != '0)))
    else $error("top entry disagrees with entry count");

  // A successful rate leaves at least one entry stored.
  a_update_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == spl_pkg::STS_UPDATED) |-> top_valid)
    else $error("update reported with an empty store");

  // A refused rate can only happen with a full store.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == spl_pkg::STS_FULL) |->
      (DEPTH > 31) || (entry_count == spl_pkg::COUNT_W'(DEPTH)))
    else $error("refusal reported with room in the store");

endmodule

bind sorted_priority_list_upsert_top spl_checker #(
  .DEPTH(DEPTH)
) u_spl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .status     (out_if.status),
  .top_valid  (out_if.top_valid),
  .top_key    (out_if.top_key),
  .top_rating (out_if.top_rating),
  .entry_count(out_if.entry_count)
);
